### rtl/core/hexrec_pkg.sv
// ----------------------------------------------------------------------------
// Hex record decoder package
// Shared codes, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package hexrec_pkg;

  // Default address width
  localparam int unsigned ADDR_WIDTH_DEF = 32;

  // Field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned SEG_W    = 20;

  // Characters
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Record status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EOF      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FORMAT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TYPE     = 3'd4;

  // Record types
  localparam logic [BYTE_W-1:0] RT_DATA     = 8'h00;
  localparam logic [BYTE_W-1:0] RT_EOF      = 8'h01;
  localparam logic [BYTE_W-1:0] RT_SEG      = 8'h02;
  localparam logic [BYTE_W-1:0] RT_SSA      = 8'h03;
  localparam logic [BYTE_W-1:0] RT_LIN      = 8'h04;
  localparam logic [BYTE_W-1:0] RT_LSA      = 8'h05;

  // Header byte positions
  localparam logic [INDEX_W-1:0] IDX_COUNT  = 9'd0;
  localparam logic [INDEX_W-1:0] IDX_OFS_HI = 9'd1;
  localparam logic [INDEX_W-1:0] IDX_OFS_LO = 9'd2;
  localparam logic [INDEX_W-1:0] IDX_TYPE   = 9'd3;
  localparam logic [INDEX_W-1:0] IDX_HEADER = 9'd4;
  localparam logic [INDEX_W-1:0] IDX_MAX    = 9'd511;

  // Decoded hex digit: valid flag and value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.val = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

### rtl/core/hex_record_decoder.sv
// ----------------------------------------------------------------------------
// Hex record decoder
// Streaming Intel HEX decoder, one text character per item.
// ----------------------------------------------------------------------------
// Takes one character per cycle unless in_stall is high and gives at most one
// result per character: the character is held in an input register, decoded
// by the record state machine and its checksum adder, and the result lands in
// the output register. Data bytes of a type 0 record come out as soon as their
// pair is complete, carrying their absolute address; the newline of each record
// whose type byte was read gives a status result.
// Data bytes of a record whose status is not zero must be discarded. After an
// error or end-of-file status the block ignores all input until reset.
// Setting cfg_skip_checksum turns off checksum verification; write it only
// while the block is idle.
module hex_record_decoder #(
  parameter int unsigned ADDR_WIDTH = hexrec_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Character input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hexrec_pkg::CHAR_W-1:0]          in_text_char,
  // Results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_kind,
  output logic [hexrec_pkg::OUT_ADDR_W-1:0]      out_byte_address,
  output logic [hexrec_pkg::BYTE_W-1:0]          out_data_byte,
  output logic [hexrec_pkg::BYTE_W-1:0]          out_record_kind,
  output logic [hexrec_pkg::STATUS_W-1:0]        out_record_status,
  // Configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_skip_checksum
);
  import hexrec_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_SKIP,
    PH_FIELDS,
    PH_BAD,
    PH_HALT
  } phase_t;

  // Registers
  logic                  skip_r;
  logic                  in_valid_r;
  logic [CHAR_W-1:0]     in_char_r;
  phase_t                phase_r, phase_nxt;
  logic [3:0]            high_nib_r, high_nib_nxt;
  logic                  nib_pend_r, nib_pend_nxt;
  logic [INDEX_W-1:0]    index_r, index_nxt;
  logic [BYTE_W-1:0]     count_r, count_nxt;
  logic [BYTE_W-1:0]     sum_r, sum_nxt;
  logic [BYTE_W-1:0]     ofs_hi_r, ofs_hi_nxt;
  logic [BYTE_W-1:0]     type_r, type_nxt;
  logic [15:0]           first_r, first_nxt;
  logic [SEG_W-1:0]      seg_r, seg_nxt;
  logic [15:0]           lin_r, lin_nxt;
  logic [ADDR_WIDTH-1:0] base_r, base_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [ADDR_WIDTH-1:0] out_addr_r;
  logic [BYTE_W-1:0]     out_data_r;
  logic [BYTE_W-1:0]     out_type_r;
  logic [STATUS_W-1:0]   out_status_r;

  // Result of the current step
  logic                  res_valid;
  logic                  res_kind;
  logic [STATUS_W-1:0]   res_status;
  logic [BYTE_W-1:0]     res_data;

  logic                  advance;
  logic                  proc;
  hex_digit_t            digit;
  logic [BYTE_W-1:0]     byte_val;
  logic [INDEX_W:0]      sum_limit;
  logic [INDEX_W:0]      need_len;
  logic [INDEX_W-1:0]    data_pos;
  logic                  in_data;
  logic [ADDR_WIDTH-1:0] seg_ext;
  logic [ADDR_WIDTH-1:0] lin_ext;

  // Handshake: the output register frees the input stage
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign proc      = in_valid_r && advance;
  assign cfg_ready = 1'b1;

  assign digit     = hex_decode(in_char_r);
  assign byte_val  = {high_nib_r, digit.val};
  assign sum_limit = {1'b0, index_r};
  assign need_len  = {2'b00, count_r} + 10'd5;
  assign data_pos  = index_r - IDX_HEADER;
  assign in_data   = (index_r >= IDX_HEADER) && (data_pos < {1'b0, count_r});

  // Decode one character
  always_comb begin
    phase_nxt    = phase_r;
    high_nib_nxt = high_nib_r;
    nib_pend_nxt = nib_pend_r;
    index_nxt    = index_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    ofs_hi_nxt   = ofs_hi_r;
    type_nxt     = type_r;
    first_nxt    = first_r;
    seg_nxt      = seg_r;
    lin_nxt      = lin_r;
    base_nxt     = base_r;
    addr_nxt     = addr_r;
    res_valid    = 1'b0;
    res_kind     = KIND_DATA;
    res_status   = ST_OK;
    res_data     = byte_val;
    seg_ext      = '0;
    lin_ext      = '0;

    if (in_char_r != CH_CR) begin
      unique case (phase_r)
        PH_START: begin
          if (in_char_r == CH_COLON) begin
            high_nib_nxt = '0;
            nib_pend_nxt = 1'b0;
            index_nxt    = '0;
            count_nxt    = '0;
            sum_nxt      = '0;
            ofs_hi_nxt   = '0;
            type_nxt     = '0;
            first_nxt    = '0;
            phase_nxt    = PH_FIELDS;
          end else if (in_char_r != CH_LF) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (in_char_r == CH_LF) begin
            phase_nxt = PH_START;
          end
        end
        PH_FIELDS, PH_BAD: begin
          if (in_char_r == CH_LF) begin
            // End of line: give the record status
            phase_nxt    = PH_START;
            nib_pend_nxt = 1'b0;
            if (index_r >= IDX_HEADER) begin
              res_valid = 1'b1;
              res_kind  = KIND_STATUS;
              res_data  = '0;
              if (phase_r == PH_BAD || {1'b0, index_r} < need_len) begin
                res_status = ST_FORMAT;
              end else if (!skip_r && sum_r != '0) begin
                res_status = ST_CHECKSUM;
              end else if (type_r == RT_EOF) begin
                res_status = ST_EOF;
              end else if (type_r == RT_DATA || type_r == RT_SSA ||
                           type_r == RT_LSA) begin
                res_status = ST_OK;
              end else if (type_r == RT_SEG) begin
                seg_nxt  = {first_r[15:8], first_r[7:0], 4'd0};
                seg_ext  = ADDR_WIDTH'(seg_nxt);
                lin_ext  = ADDR_WIDTH'({lin_r, 16'd0});
                base_nxt = seg_ext + lin_ext;
              end else if (type_r == RT_LIN) begin
                lin_nxt  = first_r;
                seg_ext  = ADDR_WIDTH'(seg_r);
                lin_ext  = ADDR_WIDTH'({lin_nxt, 16'd0});
                base_nxt = seg_ext + lin_ext;
              end else begin
                res_status = ST_TYPE;
              end
              if (res_status != ST_OK) begin
                phase_nxt = PH_HALT;
              end
            end
          end else if (phase_r == PH_FIELDS) begin
            if (!digit.ok) begin
              phase_nxt = PH_BAD;
            end else if (!nib_pend_r) begin
              high_nib_nxt = digit.val;
              nib_pend_nxt = 1'b1;
            end else begin
              // Complete pair: take one byte
              nib_pend_nxt = 1'b0;
              if (index_r == IDX_COUNT || sum_limit <= {2'b00, count_r} + 10'd4) begin
                sum_nxt = sum_r + byte_val;
              end
              if (index_r == IDX_COUNT) begin
                count_nxt = byte_val;
              end else if (index_r == IDX_OFS_HI) begin
                ofs_hi_nxt = byte_val;
              end else if (index_r == IDX_OFS_LO) begin
                addr_nxt = base_r + ADDR_WIDTH'({ofs_hi_r, byte_val});
              end else if (index_r == IDX_TYPE) begin
                type_nxt = byte_val;
              end else if (in_data) begin
                if (data_pos == '0) begin
                  first_nxt[15:8] = byte_val;
                end
                if (data_pos == INDEX_W'(1)) begin
                  first_nxt[7:0] = byte_val;
                end
                addr_nxt = addr_r + ADDR_WIDTH'(1);
                if (type_r == RT_DATA) begin
                  res_valid = 1'b1;
                end
              end
              if (index_r != IDX_MAX) begin
                index_nxt = index_r + INDEX_W'(1);
              end
            end
          end
        end
        PH_HALT: begin
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
    end
  end

  // Hold configuration, input stage, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r      <= 1'b0;
      in_valid_r  <= 1'b0;
      phase_r     <= PH_START;
      high_nib_r  <= '0;
      nib_pend_r  <= 1'b0;
      index_r     <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      ofs_hi_r    <= '0;
      type_r      <= '0;
      first_r     <= '0;
      seg_r       <= '0;
      lin_r       <= '0;
      base_r      <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        skip_r <= cfg_skip_checksum;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (proc) begin
        phase_r    <= phase_nxt;
        high_nib_r <= high_nib_nxt;
        nib_pend_r <= nib_pend_nxt;
        index_r    <= index_nxt;
        count_r    <= count_nxt;
        sum_r      <= sum_nxt;
        ofs_hi_r   <= ofs_hi_nxt;
        type_r     <= type_nxt;
        first_r    <= first_nxt;
        seg_r      <= seg_nxt;
        lin_r      <= lin_nxt;
        base_r     <= base_nxt;
        addr_r     <= addr_nxt;
      end
      if (advance) begin
        out_valid_r <= proc && res_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_char_r <= in_text_char;
    end
    if (proc && res_valid) begin
      out_kind_r   <= res_kind;
      out_addr_r   <= (res_kind == KIND_DATA) ? addr_r : '0;
      out_data_r   <= res_data;
      out_type_r   <= type_r;
      out_status_r <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_byte_address  = OUT_ADDR_W'(out_addr_r);
  assign out_data_byte     = out_data_r;
  assign out_record_kind   = out_type_r;
  assign out_record_status = out_status_r;

  // A failing or end-of-file status leaves the decoder halted
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res_valid && res_kind == KIND_STATUS && res_status != ST_OK)
      |=> phase_r == PH_HALT)
    else $error("decoder not halted after a failing status");

  // Data bytes come only from type 0 records and carry no status
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DATA)
      |-> (out_record_status == ST_OK && out_record_kind == RT_DATA))
    else $error("data byte with bad record type or status");

  // Once halted, no further result is produced
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |-> !(proc && res_valid))
    else $error("result produced while halted");

  // The input stage stalls only when it holds an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("input stalled without a pending item");

endmodule
